[src/positional_list_engine_macros.svh]
// Assertion macros for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
// Property that must hold on every clock edge outside reset
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on the next clock edge
`define PLE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

[src/ple_pkg.sv]
// Shared types and constants of the positional list engine
package ple_pkg;
  localparam int KIND_W = 3;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;
  localparam int ELEM_W = 32;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 3'd0, K_DELETE = 3'd1, K_DELALL = 3'd2,
    K_SORT = 3'd3, K_DUMPF = 3'd4, K_DUMPB = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_BADPOS = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  // Per-cycle command broadcast from the controller to every cell
  typedef enum logic [2:0] {
    C_HOLD, C_SHR, C_SHL, C_COMPACT, C_SORT, C_ROT
  } cell_op_t;
endpackage

[src/ple_if.sv]
// Valid/ready channel interfaces of the positional list engine
interface ple_in_if;
  logic                      valid;
  logic                      ready;
  logic [ple_pkg::KIND_W-1:0] kind;
  logic signed [ple_pkg::VAL_W-1:0] value;
  logic [ple_pkg::POS_W-1:0] position;
  modport source (output valid, kind, value, position, input ready);
  modport sink (input valid, kind, value, position, output ready);
endinterface

interface ple_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [ple_pkg::ELEM_W-1:0] element;
  logic [ple_pkg::CNT_W-1:0] count;
  logic [1:0]                status;
  logic                      last;
  modport source (output valid, element, count, status, last, input ready);
  modport sink (input valid, element, count, status, last, output ready);
endinterface

[src/positional_list_engine.sv]
// Top level: positional list engine built on a chain of element cells
// Insert and delete step the chain in a shift state, sort in odd-even passes, delete-all
// scans the list and drops matches; refused requests go straight to the result state.
// Dumps give the first result from the dump state, then one per cycle while taken.
// One request at a time: the next is taken the cycle after its last result leaves.
// Synchronous active-low reset empties the list; element contents need no reset.
module positional_list_engine #(
  parameter int CAPACITY = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  ple_in_if.sink in_ch,
  ple_out_if.source out_ch
);
  import ple_pkg::*;
  `include "positional_list_engine_macros.svh"

  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_DALL, S_SORT, S_DUMP, S_OUT} state_t;

  state_t state_r;
  logic [OW-1:0] occ_r;
  logic [OW-1:0] step_r;
  logic [OW-1:0] cnt_r;   // elements removed in delete all
  logic [OW-1:0] idx_r;   // compaction scan position
  kind_t kind_r;
  logic [IW-1:0] pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic out_valid_r, out_last_r;
  logic [DATA_WIDTH-1:0] out_elem_r;
  logic [OW-1:0] out_cnt_r;
  status_t out_st_r;
  cell_op_t op;
  logic [DATA_WIDTH-1:0] cv [CAPACITY];
  logic [CAPACITY-1:0] en_v, load_v, take_v;
  logic match;

  // Hold off a new request until the previous result has left
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.element = ELEM_W'($signed(out_elem_r));
  assign out_ch.count = CNT_W'(out_cnt_r);
  assign out_ch.status = out_st_r;
  assign out_ch.last = out_last_r;

  assign match = (cv[idx_r[IW-1:0]] == val_r);

  // Drive per-cell controls
  always_comb begin
    op = C_HOLD;
    en_v = '0;
    load_v = '0;
    take_v = '0;
    case (state_r)
      S_SHIFT: begin
        op = (kind_r == K_INSERT) ? C_SHR : C_SHL;
        for (int i = 0; i < CAPACITY; i++) begin
          en_v[i] = (i >= int'(pos_r)) && (i <= int'(occ_r));
          load_v[i] = (i == int'(pos_r));
        end
      end
      S_DALL: begin
        // drop matching slot by shifting the tail left
        op = C_SHL;
        for (int i = 0; i < CAPACITY; i++)
          en_v[i] = match && (i >= int'(idx_r)) && (i < int'(occ_r));
      end
      S_SORT: begin
        op = C_SORT;
        en_v = '1;
      end
      S_DUMP: begin
        op = C_ROT;
        en_v = '0;
      end
      default: op = C_HOLD;
    endcase
  end

  // Instantiate the chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic odd, pair_en;
    assign odd = ((g % 2) == (step_r[0] ? 1 : 0));
    assign pair_en = odd ? (g + 1 < int'(occ_r)) : (g >= 1 && g < int'(occ_r));
    ple_cell #(.DW(DATA_WIDTH)) u_cell (
      .clk(clk), .op(op), .en(en_v[g]), .load(load_v[g]), .new_val(val_r),
      .left_val(cv[(g == 0) ? 0 : g - 1]),
      .right_val(cv[(g == CAPACITY - 1) ? g : g + 1]),
      .take_right(take_v[g]), .odd(odd),
      .pair_en(pair_en), .val(cv[g])
    );
  end

  // Controller: accept request, step the chain, issue results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r <= '0;
      out_valid_r <= 1'b0;
      step_r <= '0;
    end else begin
      // drop a taken result unless a new one is loaded this cycle
      if (out_ch.valid && out_ch.ready && !(state_r inside {S_DUMP, S_OUT}))
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          kind_r <= kind_t'(in_ch.kind);
          val_r <= DATA_WIDTH'($signed(in_ch.value));
          pos_r <= IW'(in_ch.position - 5'd1);
          out_elem_r <= '0;
          out_last_r <= 1'b1;
          step_r <= '0;
          cnt_r <= '0;
          idx_r <= '0;
          out_cnt_r <= occ_r;
          out_st_r <= ST_OK;
          case (in_ch.kind)
            K_INSERT: begin
              if (occ_r >= OW'(CAPACITY)) begin
                out_st_r <= ST_FULL; state_r <= S_OUT;
              end else if (in_ch.position < 5'd1 ||
                           32'(in_ch.position) > 32'(occ_r) + 1) begin
                out_st_r <= ST_BADPOS; state_r <= S_OUT;
              end else state_r <= S_SHIFT;
            end
            K_DELETE: begin
              if (occ_r == '0) begin
                out_st_r <= ST_EMPTY; state_r <= S_OUT;
              end else if (in_ch.position < 5'd1 ||
                           32'(in_ch.position) > 32'(occ_r)) begin
                out_st_r <= ST_BADPOS; state_r <= S_OUT;
              end else state_r <= S_SHIFT;
            end
            K_DELALL: state_r <= S_DALL;
            K_SORT: state_r <= S_SORT;
            K_DUMPF, K_DUMPB: begin
              if (occ_r == '0) begin
                out_st_r <= ST_EMPTY; out_cnt_r <= '0; state_r <= S_OUT;
              end else state_r <= S_DUMP;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_SHIFT: begin
          occ_r <= (kind_r == K_INSERT) ? occ_r + 1'b1 : occ_r - 1'b1;
          out_cnt_r <= (kind_r == K_INSERT) ? occ_r + 1'b1 : occ_r - 1'b1;
          state_r <= S_OUT;
        end
        S_DALL: begin
          if (idx_r >= occ_r) begin
            out_cnt_r <= cnt_r;
            state_r <= S_OUT;
          end else if (match) begin
            occ_r <= occ_r - 1'b1;
            cnt_r <= cnt_r + 1'b1;
          end else idx_r <= idx_r + 1'b1;
        end
        S_SORT: begin
          step_r <= step_r + 1'b1;
          if (step_r == OW'(CAPACITY - 1)) state_r <= S_OUT;
        end
        S_DUMP: if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          out_cnt_r <= occ_r;
          out_st_r <= ST_OK;
          out_elem_r <= (kind_r == K_DUMPB) ? cv[IW'(occ_r - 1'b1 - step_r)]
                                             : cv[step_r[IW-1:0]];
          out_last_r <= (step_r + 1'b1 == occ_r);
          step_r <= step_r + 1'b1;
          if (step_r + 1'b1 == occ_r) state_r <= S_IDLE;
        end
        S_OUT: if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PLE_ASSERT(a_occ_range, occ_r <= OW'(CAPACITY), "occupancy above capacity")
  `PLE_ASSERT_NEXT(a_hold_out, out_valid_r && !out_ch.ready, out_valid_r, "result dropped")
  `PLE_ASSERT(a_busy_ready, (state_r != S_IDLE) |-> !in_ch.ready, "ready while busy")
endmodule

[src/ple_cell.sv]
// One list slot: holds an element and trades it with its neighbors
module ple_cell #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  ple_pkg::cell_op_t op,
  input  logic          en,        // slot takes part this cycle
  input  logic          load,      // slot takes the new value on shift right
  input  logic [DW-1:0] new_val,
  input  logic [DW-1:0] left_val,  // neighbor nearer the front
  input  logic [DW-1:0] right_val, // neighbor nearer the back
  input  logic          take_right,// compaction: take right neighbor
  input  logic          odd,       // sort: slot is lower of its pair
  input  logic          pair_en,   // sort: pair lies within the list
  output logic [DW-1:0] val
);
  import ple_pkg::*;
  logic [DW-1:0] val_r, val_nxt;
  assign val = val_r;

  // Select next content by broadcast command
  always_comb begin
    val_nxt = val_r;
    if (en) begin
      case (op)
        C_SHR: val_nxt = load ? new_val : left_val;
        C_SHL: val_nxt = right_val;
        C_COMPACT: if (take_right) val_nxt = right_val;
        C_ROT: val_nxt = right_val;
        C_SORT: if (pair_en) begin
          if (odd) val_nxt = ($signed(right_val) < $signed(val_r)) ? right_val : val_r;
          else val_nxt = ($signed(val_r) < $signed(left_val)) ? left_val : val_r;
        end
        default: val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
endmodule

[dv/ple_tb_if.sv]
// Testbench types for the positional list engine: expected result record
`timescale 1ns / 100ps
package ple_tb_pkg;
  import ple_pkg::*;
  // one expected result of the list engine
  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [CNT_W-1:0]         count;
    status_t                  status;
    logic                     last;
  } ple_result_t;
endpackage

[dv/positional_list_engine_test.sv]
// Testbench for the positional list engine: shadow list, directed and random requests
`timescale 1ns / 100ps
module positional_list_engine_test;
  import ple_pkg::*;
  import ple_tb_pkg::*;

  localparam int CAP = 16;
  localparam int KIND_UNUSED = 6;

  logic clk;
  logic rst_n;
  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine #(.CAPACITY(CAP), .DATA_WIDTH(32)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // shadow list and pending results
  logic signed [31:0] shadow_list [CAP];
  int unsigned        shadow_len;
  ple_result_t        pending_results [$];
  int                 mismatch_cnt;
  int                 result_cnt;
  int                 request_cnt;
  bit                 calm;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, result_cnt);
    mismatch_cnt++;
  endtask

  task automatic push_result(input logic signed [31:0] e, input int unsigned c,
                             input status_t s, input logic l);
    ple_result_t r;
    r.element = e; r.count = c[4:0]; r.status = s; r.last = l;
    pending_results.push_back(r);
  endtask

  // compute the results of one operation and update the shadow list
  task automatic predict_list_op(input kind_t k, input logic signed [31:0] v,
                                 input int unsigned p);
    int unsigned kept;
    logic signed [31:0] t;
    int unsigned m;
    case (k)
      K_INSERT: begin
        if (shadow_len >= CAP) push_result(0, shadow_len, ST_FULL, 1);
        else if (p < 1 || p > shadow_len + 1) push_result(0, shadow_len, ST_BADPOS, 1);
        else begin
          for (int i = shadow_len; i >= p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = v;
          shadow_len++;
          push_result(0, shadow_len, ST_OK, 1);
        end
      end
      K_DELETE: begin
        if (shadow_len == 0) push_result(0, 0, ST_EMPTY, 1);
        else if (p < 1 || p > shadow_len) push_result(0, shadow_len, ST_BADPOS, 1);
        else begin
          for (int i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          push_result(0, shadow_len, ST_OK, 1);
        end
      end
      K_DELALL: begin
        kept = 0;
        for (int i = 0; i < shadow_len; i++)
          if (shadow_list[i] != v) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        push_result(0, shadow_len - kept, ST_OK, 1);
        shadow_len = kept;
      end
      K_SORT: begin
        for (int i = 0; i < shadow_len; i++) begin
          m = i;
          for (int j = i + 1; j < shadow_len; j++)
            if (shadow_list[j] < shadow_list[m]) m = j;
          t = shadow_list[i]; shadow_list[i] = shadow_list[m]; shadow_list[m] = t;
        end
        push_result(0, shadow_len, ST_OK, 1);
      end
      K_DUMPF, K_DUMPB: begin
        if (shadow_len == 0) push_result(0, 0, ST_EMPTY, 1);
        else
          for (int i = 0; i < shadow_len; i++)
            push_result(shadow_list[k == K_DUMPB ? shadow_len - 1 - i : i],
                        shadow_len, ST_OK, i + 1 == shadow_len);
      end
      default: ;
    endcase
  endtask

  // send one request, idling now and then; valid stays up between back-to-back requests
  task automatic send_request(input logic [2:0] k, input logic signed [31:0] v,
                              input logic [4:0] p);
    while (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.value    <= v;
    in_ch.position <= p;
    do @(posedge clk); while (!in_ch.ready);
    request_cnt++;
    predict_list_op(kind_t'(k), v, 32'(p));
  endtask

  // result side: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    ple_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (pending_results.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = pending_results.pop_front();
          if (out_ch.element !== want.element)
            report_mismatch("element", out_ch.element, want.element);
          if (out_ch.count !== want.count)
            report_mismatch("count", 32'(out_ch.count), 32'(want.count));
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.last !== want.last)
            report_mismatch("last", 32'(out_ch.last), 32'(want.last));
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic fill_to(input int unsigned n);
    while (shadow_len < n)
      send_request(K_INSERT, $urandom, 5'($urandom_range(1, shadow_len + 1)));
  endtask

  // empty list: every operation plus dump flagged empty
  task automatic test_empty_list();
    send_request(K_DELETE, 0, 1);
    send_request(K_DUMPF, 0, 0);
    send_request(K_DUMPB, 0, 0);
    send_request(K_SORT, 0, 0);
    send_request(K_DELALL, 5, 0);
    send_request(K_INSERT, 7, 0);
    send_request(K_INSERT, 7, 2);
  endtask

  // value extremes, bad positions, unused kinds
  task automatic test_edges();
    send_request(K_INSERT, 32'sh7fffffff, 1);
    send_request(K_INSERT, 32'sh80000000, 2);
    send_request(K_INSERT, -1, 1);
    send_request(K_INSERT, 0, 4);
    send_request(K_INSERT, 3, 31);
    send_request(K_DELETE, 0, 5);
    send_request(K_DELETE, 0, 0);
    send_request(3'(KIND_UNUSED), 1, 1);
    send_request(3'd7, -1, 31);
    send_request(K_SORT, 0, 0);
    send_request(K_DUMPB, 0, 0);
    send_request(K_DELALL, 3, 0);
    send_request(K_DELETE, 0, 4);
    send_request(K_DUMPF, 0, 0);
  endtask

  // full list: insert refused, full sort and a forward dump
  task automatic test_full_list();
    fill_to(CAP);
    send_request(K_INSERT, 1, 1);
    send_request(K_INSERT, 1, 31);
    send_request(K_SORT, 0, 0);
    send_request(K_DUMPF, 0, 0);
  endtask

  // random requests with repeated values so delete-all hits
  task automatic test_random_ops();
    logic [2:0] k;
    logic signed [31:0] v;
    for (int n = 0; n < 60; n++) begin
      calm = (n >= 20 && n < 40);
      k = $urandom_range(99) < 3 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (k == K_INSERT && $urandom_range(2) != 0) k = K_INSERT;
      v = $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(8)) - 4);
      send_request(k, v, $urandom_range(99) < 85 ? 5'($urandom_range(1, shadow_len + 1))
                                                 : 5'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.value = '0; in_ch.position = '0;
    out_ch.ready = 1'b0;
    shadow_len = 0; mismatch_cnt = 0; result_cnt = 0; request_cnt = 0; calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edges();
    test_full_list();
    test_random_ops();
    in_ch.valid <= 1'b0;
    drain_results();
    repeat (60) @(posedge clk);
    $display("covered %0d requests, %0d results checked", request_cnt, result_cnt);
    $display("all kinds, empty/full lists, bad positions and unused kinds exercised");
    if (mismatch_cnt == 0 && pending_results.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
